### rtl/min_max_heap_insert_assert.svh
// Assertion macros used by the min-max heap insert controller.
`ifndef MIN_MAX_HEAP_INSERT_ASSERT_SVH
`define MIN_MAX_HEAP_INSERT_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define MMHI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define MMHI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mmhi_pkg.sv
// Package with the types, constants and helper functions of the min-max heap insert block.
`timescale 1ns / 1ps
`default_nettype none

package mmhi_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_BITS  = 20;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int LVL_BITS  = $clog2(CNT_BITS);

    localparam int CMD_BITS       = 2;
    localparam int STATUS_BITS    = 2;
    localparam int KEY_FIELD_BITS = 20;
    localparam int ID_FIELD_BITS  = 11;
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_FIELD_BITS = 3 * (ID_FIELD_BITS + KEY_FIELD_BITS);
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [CNT_BITS-1:0] id;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        ADDR_ROOT  = 3'd0,
        ADDR_PAR   = 3'd1,
        ADDR_GRAND = 3'd2,
        ADDR_LAST  = 3'd3,
        ADDR_LEFT  = 3'd4
    } addr_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      clear_cnt;
        logic      inc_cnt;
        logic      mark_full;
        logic      wr_en;
        logic      wsel_new;
        addr_sel_t addr_sel;
        logic      hole_par;
        logic      hole_grand;
        logic      set_dir;
        logic      cap_root;
        logic      cap_last;
        logic      cap_left;
        logic      load_out;
    } dp_ctrl_t;

    typedef struct packed {
        logic full;
        logic hole_zero;
        logic hole_small;
        logic swap;
        logic move;
    } dp_stat_t;

    // Index of the highest set bit.
    function automatic logic [LVL_BITS-1:0] msb_index(input logic [CNT_BITS-1:0] v);
        logic [LVL_BITS-1:0] idx;
        idx = '0;
        for (int i = 0; i < CNT_BITS; i++)
        begin
            if (v[i])
            begin
                idx = LVL_BITS'(i);
            end
        end
        return idx;
    endfunction

    // Even tree depths, the root's included, are min levels.
    function automatic logic on_min_level(input logic [ADDR_BITS-1:0] pos);
        logic [LVL_BITS-1:0] depth;
        depth = msb_index(CNT_BITS'(pos) + CNT_BITS'(1));
        return ~depth[0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] parent_of(input logic [ADDR_BITS-1:0] pos);
        return (pos - ADDR_BITS'(1)) >> 1;
    endfunction

endpackage

`default_nettype wire

### rtl/mmhi_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mmhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/mmhi_datapath.sv
// Datapath of the min-max heap insert block: heap memory, hole pointer, count and result registers.
`timescale 1ns / 1ps
`default_nettype none

module mmhi_datapath
    import mmhi_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [KEY_FIELD_BITS-1:0] key_value,
    input  wire dp_ctrl_t                  ctrl,
    output dp_stat_t                       stat,
    output logic [STATUS_BITS-1:0]         out_status,
    output logic [OUT_TDATA_BITS-1:0]      out_data
);

    logic [CNT_BITS-1:0]       count_reg, count_next;
    entry_t                    new_reg;
    logic [ADDR_BITS-1:0]      hole_reg;
    logic                      want_min_reg;
    logic [STATUS_BITS-1:0]    status_reg;
    entry_t                    root_reg, last_reg, left_reg;
    logic [STATUS_BITS-1:0]    out_status_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;

    logic [ENTRY_BITS-1:0] ram_rdata;
    entry_t                rd_entry;
    entry_t                wr_entry;
    logic [ADDR_BITS-1:0]  raddr;
    logic [ADDR_BITS-1:0]  par_addr, grand_addr, last_addr, left_addr;
    logic                  is_min;

    assign rd_entry   = entry_t'(ram_rdata);
    assign wr_entry   = ctrl.wsel_new ? new_reg : rd_entry;
    assign par_addr   = parent_of(hole_reg);
    assign grand_addr = parent_of(par_addr);
    assign last_addr  = ADDR_BITS'(count_reg - CNT_BITS'(1));
    assign left_addr  = ADDR_BITS'((CNT_BITS'(1) << msb_index(count_reg)) - CNT_BITS'(1));
    assign is_min     = on_min_level(hole_reg);

    always_comb
    begin
        unique case (ctrl.addr_sel)
            ADDR_ROOT:  raddr = '0;
            ADDR_PAR:   raddr = par_addr;
            ADDR_GRAND: raddr = grand_addr;
            ADDR_LAST:  raddr = last_addr;
            ADDR_LEFT:  raddr = left_addr;
            default:    raddr = '0;
        endcase
    end

    // A min-level slot swaps with a smaller parent, a max-level slot with a larger one.
    assign stat.full       = (count_reg == CNT_BITS'(CAPACITY));
    assign stat.hole_zero  = (hole_reg == '0);
    assign stat.hole_small = (hole_reg < ADDR_BITS'(3));
    assign stat.swap       = is_min ? (new_reg.key > rd_entry.key) : (new_reg.key < rd_entry.key);
    assign stat.move       = want_min_reg ? (new_reg.key < rd_entry.key)
                                          : (new_reg.key > rd_entry.key);

    mmhi_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .clk  (clk),
        .we   (ctrl.wr_en),
        .waddr(hole_reg),
        .wdata(wr_entry),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear_cnt)
        begin
            count_next = '0;
        end
        else if (ctrl.inc_cnt)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            new_reg.id  <= count_reg + CNT_BITS'(1);
            new_reg.key <= KEY_BITS'(key_value);
            hole_reg    <= ADDR_BITS'(count_reg);
            status_reg  <= ctrl.mark_full ? STATUS_FULL : STATUS_OK;
        end
        else if (ctrl.hole_par)
        begin
            hole_reg <= par_addr;
        end
        else if (ctrl.hole_grand)
        begin
            hole_reg <= grand_addr;
        end

        if (ctrl.set_dir)
        begin
            want_min_reg <= is_min ^ stat.swap;
        end
        if (ctrl.cap_root)
        begin
            root_reg <= rd_entry;
        end
        if (ctrl.cap_last)
        begin
            last_reg <= rd_entry;
        end
        if (ctrl.cap_left)
        begin
            left_reg <= rd_entry;
        end

        if (ctrl.load_out)
        begin
            if (count_reg == '0)
            begin
                out_status_reg <= STATUS_EMPTY;
                out_data_reg   <= '0;
            end
            else
            begin
                out_status_reg <= status_reg;
                out_data_reg   <= {{OUT_PAD_BITS{1'b0}},
                                   KEY_FIELD_BITS'(left_reg.key), ID_FIELD_BITS'(left_reg.id),
                                   KEY_FIELD_BITS'(last_reg.key), ID_FIELD_BITS'(last_reg.id),
                                   KEY_FIELD_BITS'(root_reg.key), ID_FIELD_BITS'(root_reg.id)};
            end
        end
    end

    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;

endmodule

`default_nettype wire

### rtl/mmhi_ctrl.sv
// Controller state machine of the min-max heap insert block.
`timescale 1ns / 1ps
`default_nettype none

`include "min_max_heap_insert_assert.svh"

module mmhi_ctrl
    import mmhi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [CMD_BITS-1:0] cmd,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output dp_ctrl_t                 ctrl,
    input  wire dp_stat_t            stat
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_PAR_REQ   = 10'b00_0000_0010,
        S_PAR_CMP   = 10'b00_0000_0100,
        S_CLIMB_REQ = 10'b00_0000_1000,
        S_CLIMB_CMP = 10'b00_0001_0000,
        S_RD_ROOT   = 10'b00_0010_0000,
        S_RD_LAST   = 10'b00_0100_0000,
        S_RD_LEFT   = 10'b00_1000_0000,
        S_CAP_LEFT  = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.addr_sel = ADDR_ROOT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.load_in = 1'b1;
                    if (cmd == CMD_CLEAR)
                    begin
                        ctrl.clear_cnt = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if ((cmd == CMD_INSERT) && !stat.full)
                    begin
                        ctrl.inc_cnt = 1'b1;
                        state_next   = S_PAR_REQ;
                    end
                    else
                    begin
                        ctrl.mark_full = (cmd == CMD_INSERT);
                        state_next     = S_RD_ROOT;
                    end
                end
            end
            S_PAR_REQ:
            begin
                if (stat.hole_zero)
                begin
                    ctrl.wr_en    = 1'b1;
                    ctrl.wsel_new = 1'b1;
                    state_next    = S_RD_ROOT;
                end
                else
                begin
                    ctrl.addr_sel = ADDR_PAR;
                    state_next    = S_PAR_CMP;
                end
            end
            S_PAR_CMP:
            begin
                // On a swap the parent moves down into the hole, and the climb turns to the other levels.
                ctrl.addr_sel = ADDR_PAR;
                ctrl.set_dir  = 1'b1;
                if (stat.swap)
                begin
                    ctrl.wr_en    = 1'b1;
                    ctrl.hole_par = 1'b1;
                end
                state_next = S_CLIMB_REQ;
            end
            S_CLIMB_REQ:
            begin
                if (stat.hole_small)
                begin
                    ctrl.wr_en    = 1'b1;
                    ctrl.wsel_new = 1'b1;
                    state_next    = S_RD_ROOT;
                end
                else
                begin
                    ctrl.addr_sel = ADDR_GRAND;
                    state_next    = S_CLIMB_CMP;
                end
            end
            S_CLIMB_CMP:
            begin
                ctrl.addr_sel = ADDR_GRAND;
                ctrl.wr_en    = 1'b1;
                if (stat.move)
                begin
                    ctrl.hole_grand = 1'b1;
                    state_next      = S_CLIMB_REQ;
                end
                else
                begin
                    ctrl.wsel_new = 1'b1;
                    state_next    = S_RD_ROOT;
                end
            end
            S_RD_ROOT:
            begin
                ctrl.addr_sel = ADDR_ROOT;
                state_next    = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                ctrl.addr_sel = ADDR_LAST;
                ctrl.cap_root = 1'b1;
                state_next    = S_RD_LEFT;
            end
            S_RD_LEFT:
            begin
                ctrl.addr_sel = ADDR_LEFT;
                ctrl.cap_last = 1'b1;
                state_next    = S_CAP_LEFT;
            end
            S_CAP_LEFT:
            begin
                ctrl.cap_left = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    `MMHI_ASSERT_NOW(a_no_overwrite, ctrl.load_out, (!out_valid_reg || m_tready), "result beat overwritten before it was taken")
    `MMHI_ASSERT_NEXT(a_busy_after_accept, (s_tvalid && s_tready), (state_reg != S_IDLE), "block still idle after an accepted beat")
    `MMHI_ASSERT_NOW(a_write_states, ctrl.wr_en, (state_reg == S_PAR_REQ || state_reg == S_PAR_CMP || state_reg == S_CLIMB_REQ || state_reg == S_CLIMB_CMP), "heap write outside the insert states")
    `MMHI_ASSERT_NEXT(a_result_follows_done, ctrl.load_out, m_tvalid, "result not presented after load")

endmodule

`default_nettype wire

### rtl/min_max_heap_insert.sv
// Top level of the min-max heap insert block.
// Usage:
//   The slave channel takes one command beat: tuser carries the command (clear, insert or
//   report only) and tdata carries the key for an insert. Every command gives exactly one
//   result beat on the master channel: tuser carries the status (ok, insert dropped because
//   the heap is full, heap empty) and tdata the id and key of the root, of the last slot and
//   of the leftmost slot of the deepest level, all zero when the heap is empty.
//   One command is worked on at a time in a heap memory with one write port and one
//   registered read port. A clear goes straight to loading the result register; a report or a
//   dropped insert reads the root, the last slot and the leftmost slot first. An insert into an
//   empty heap writes the root, and any other insert compares with its parent and then climbs
//   by grandparents until it reaches the top two levels or a compare stops it, before the same
//   reads. Each grandparent move is one memory read and one write, and at most 5 moves occur
//   for 1024 entries. The next command can be accepted in the cycle after the result is loaded.
//   The result sits in an output register; the block accepts and works on the next command
//   while the receiver stalls, and waits only when that command's result is ready to load.
//   Reset empties the heap at once (the entry count is cleared) and drops any pending result;
//   no clearing pass runs over the memory.
`timescale 1ns / 1ps
`default_nettype none

module min_max_heap_insert
    import mmhi_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,  // key_value
    input  wire logic [CMD_BITS-1:0]       s_tuser,  // cmd
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // root_id, root_key, last_id, last_key, leftmost_id, leftmost_key
    output logic      [OUT_TDATA_BITS-1:0] m_tdata,
    output logic      [STATUS_BITS-1:0]    m_tuser   // status
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    mmhi_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .cmd     (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    mmhi_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_value (s_tdata[KEY_FIELD_BITS-1:0]),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_status(m_tuser),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
